### hdl/sac_pkg.sv
package sac_pkg;

    // fill value written into a line on allocation
    localparam logic [7:0] FILL_BYTE = 8'h42;

    // command field codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 8;
    localparam int WAY_OUT_W  = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // controller to datapath commands
    typedef struct packed {
        logic clear;    // write one zero rank row during the clearing pass
        logic load;     // capture the incoming request word
        logic read;     // read tag and rank rows of the set
        logic decide;   // register hit and chosen way
        logic update;   // write tag, rank and line memories
        logic respond;  // load the output register
    } sac_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;  // last rank row is being cleared
    } sac_status_t;

endpackage

### hdl/sac_ctrl.sv
module sac_ctrl
    import sac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  sac_status_t status,
    output sac_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.respond    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/sac_datapath.sv
module sac_datapath
    import sac_pkg::*;
#(
    parameter int WAYS       = 8,
    parameter int SETS       = 128,
    parameter int LINE_BYTES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sac_cmd_t               cmd,
    output sac_status_t            status,
    input  logic [IN_TDATA_W-1:0]  in_data,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
    localparam int RANK_W = $clog2(WAYS + 1);
    localparam int LINES  = SETS * WAYS;
    localparam int LINE_W = SET_W + WAY_W;

    typedef logic [WAYS-1:0][TAG_W-1:0]       tag_row_t;
    typedef logic [WAYS-1:0][RANK_W-1:0]      rank_row_t;
    typedef logic [LINE_BYTES-1:0][DATA_W-1:0] line_t;

    // memories
    tag_row_t  tag_mem  [SETS];
    rank_row_t rank_mem [SETS];
    line_t     line_mem [LINES];

    // request registers
    logic              req_cmd_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [DATA_W-1:0] req_wdata_reg;
    logic [SET_W-1:0]  clear_idx_reg;

    tag_row_t          tag_rd_reg;
    rank_row_t         rank_rd_reg;
    line_t             line_rd_reg;
    logic              hit_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_rdata_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;

    logic [OFF_W-1:0]  req_off;
    logic [SET_W-1:0]  req_set;
    logic [TAG_W-1:0]  req_tag;
    logic [LINE_W-1:0] line_idx;

    logic              hit_any;
    logic [WAY_W-1:0]  hit_way;
    logic              empty_any;
    logic [WAY_W-1:0]  empty_way;
    logic [WAY_W-1:0]  oldest_way;
    logic [RANK_W-1:0] old_rank;
    rank_row_t         rank_new;
    rank_row_t         rank_wr;
    logic [SET_W-1:0]  rank_addr;
    logic              rank_we;
    tag_row_t          tag_new;
    line_t             line_wr;
    logic [LINE_BYTES-1:0] line_be;
    logic [DATA_W-1:0] rdata_sel;

    assign req_off  = req_addr_reg[OFF_W-1:0];
    assign req_set  = req_addr_reg[OFF_W +: SET_W];
    assign req_tag  = req_addr_reg[OFF_W + SET_W +: TAG_W];
    assign line_idx = {req_set, way_reg};

    assign status.clear_last = (clear_idx_reg == SET_W'(SETS - 1));

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_cmd_reg   <= in_data[0];
            req_addr_reg  <= in_data[1 +: ADDR_W];
            req_wdata_reg <= in_data[1 + ADDR_W +: DATA_W];
        end
    end

    // tag match and victim choice, lowest way wins
    always_comb
    begin
        hit_any    = 1'b0;
        hit_way    = '0;
        empty_any  = 1'b0;
        empty_way  = '0;
        oldest_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rank_rd_reg[w] != '0 && tag_rd_reg[w] == req_tag)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (rank_rd_reg[w] == '0)
            begin
                empty_any = 1'b1;
                empty_way = WAY_W'(w);
            end
            // with all ways valid the ranks are 1..WAYS, the oldest holds WAYS
            if (rank_rd_reg[w] == RANK_W'(WAYS))
            begin
                oldest_way = WAY_W'(w);
            end
        end
    end

    // decision registers
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            hit_reg <= hit_any;
            priority if (hit_any)
                way_reg <= hit_way;
            else if (empty_any)
                way_reg <= empty_way;
            else
                way_reg <= oldest_way;
        end
    end

    // recency update
    always_comb
    begin
        old_rank = rank_rd_reg[way_reg];
        tag_new  = tag_rd_reg;
        tag_new[way_reg] = req_tag;
        for (int w = 0; w < WAYS; w++)
        begin
            rank_new[w] = rank_rd_reg[w];
            if (WAY_W'(w) == way_reg)
            begin
                rank_new[w] = RANK_W'(1);
            end
            else if (rank_rd_reg[w] != '0 &&
                     (old_rank == '0 || rank_rd_reg[w] < old_rank))
            begin
                rank_new[w] = rank_rd_reg[w] + 1'b1;
            end
        end
    end

    assign rank_we   = cmd.clear | cmd.update;
    assign rank_addr = cmd.clear ? clear_idx_reg : req_set;
    assign rank_wr   = cmd.clear ? '0 : rank_new;

    // tag and rank memories
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_addr] <= rank_wr;
        end
        if (cmd.update && !hit_reg)
        begin
            tag_mem[req_set] <= tag_new;
        end
        if (cmd.read)
        begin
            tag_rd_reg  <= tag_mem[req_set];
            rank_rd_reg <= rank_mem[req_set];
        end
    end

    // line write word: fill on miss, merge the written byte
    always_comb
    begin
        for (int b = 0; b < LINE_BYTES; b++)
        begin
            line_wr[b] = FILL_BYTE;
            line_be[b] = ~hit_reg;
            if (OFF_W'(b) == req_off && req_cmd_reg == CMD_WRITE)
            begin
                line_wr[b] = req_wdata_reg;
                line_be[b] = 1'b1;
            end
        end
    end

    // line memory
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            for (int b = 0; b < LINE_BYTES; b++)
            begin
                if (line_be[b])
                begin
                    line_mem[line_idx][b] <= line_wr[b];
                end
            end
            line_rd_reg <= line_mem[line_idx];
        end
    end

    // result byte
    always_comb
    begin
        priority if (req_cmd_reg == CMD_WRITE)
            rdata_sel = '0;
        else if (!hit_reg)
            rdata_sel = FILL_BYTE;
        else
            rdata_sel = line_rd_reg[req_off];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            out_hit_reg   <= hit_reg;
            out_rdata_reg <= rdata_sel;
            out_way_reg   <= WAY_OUT_W'(way_reg);
        end
    end

    assign out_data = {{(OUT_TDATA_W - 1 - DATA_W - WAY_OUT_W){1'b0}},
                       out_way_reg, out_rdata_reg, out_hit_reg};

endmodule

### hdl/set_assoc_cache_lru.sv
// Set-associative byte cache with least-recently-used replacement. Each input
// word is one byte read or write; each gives exactly one output word with the
// hit flag, the byte read (0x42 on a read miss, 0 on a write) and the way used.
// After reset the block runs a clearing pass over the recency memory, one set
// per cycle, and takes no word until it ends. An access then proceeds from
// acceptance to a valid output word: the request is captured at acceptance,
// then the tag and recency rows of the set are read, the match and victim are
// decided, the recency memory and, as needed, the tag and line memories are
// written, and the result is registered. One access is in flight at a time and
// the controller returns to idle only after the result is registered, so no new
// word is taken before then; the output register lets the next word enter while
// a result waits. WAYS, SETS and LINE_BYTES must be powers of two.
module set_assoc_cache_lru
    import sac_pkg::*;
#(
    parameter int WAYS       = 8,
    parameter int SETS       = 128,
    parameter int LINE_BYTES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // command, address, write_data
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hit, read_data, way_used
);

    sac_cmd_t    cmd;
    sac_status_t status;

    // controller
    sac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    sac_datapath #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

### dv/tb_set_assoc_cache_lru.sv
module tb_set_assoc_cache_lru;
    import sac_pkg::*;

    localparam int NWAYS = 8;
    localparam int NSETS = 128;
    localparam int LBYTES = 32;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic       hit;
        logic [7:0] rdata;
        logic [2:0] way;
    } access_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;   // command, address, write_data
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // hit, read_data, way_used

    // predictor state
    logic [19:0] tag_mem [NSETS*NWAYS];
    logic [3:0]  rank_mem [NSETS*NWAYS];
    logic [7:0]  byte_mem [NSETS*NWAYS*LBYTES];

    access_result_t expected_q[$];
    int mismatches;
    int words_sent;
    int words_checked;
    int hits_seen;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;

    set_assoc_cache_lru uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    // compute the expected result of one access and update the cache image
    function automatic access_result_t predict_access(logic cmd, logic [31:0] addr,
                                                      logic [7:0] wdata);
        access_result_t res;
        int set_base;
        int way;
        int best_rank;
        logic [3:0] old_rank;
        logic found;
        set_base = int'(addr[11:5]) * NWAYS;
        found = 1'b0;
        way = 0;
        res = '0;
        for (int w = 0; w < NWAYS; w++)
        begin
            if (!found && rank_mem[set_base+w] != 0 && tag_mem[set_base+w] == addr[31:12])
            begin
                found = 1'b1;
                way = w;
            end
        end
        if (!found)
        begin
            // victim: first empty way, else oldest
            way = -1;
            for (int w = NWAYS - 1; w >= 0; w--)
                if (rank_mem[set_base+w] == 0)
                    way = w;
            if (way < 0)
            begin
                best_rank = 0;
                for (int w = 0; w < NWAYS; w++)
                begin
                    if (rank_mem[set_base+w] > best_rank)
                    begin
                        best_rank = rank_mem[set_base+w];
                        way = w;
                    end
                end
            end
            for (int b = 0; b < LBYTES; b++)
                byte_mem[(set_base+way)*LBYTES+b] = FILL_BYTE;
            tag_mem[set_base+way] = addr[31:12];
        end
        if (cmd == CMD_WRITE)
            byte_mem[(set_base+way)*LBYTES+int'(addr[4:0])] = wdata;
        else
            res.rdata = byte_mem[(set_base+way)*LBYTES+int'(addr[4:0])];
        // recency update
        old_rank = rank_mem[set_base+way];
        for (int w = 0; w < NWAYS; w++)
        begin
            if (w != way && rank_mem[set_base+w] != 0 &&
                (old_rank == 0 || rank_mem[set_base+w] < old_rank))
                rank_mem[set_base+w] = rank_mem[set_base+w] + 1;
        end
        rank_mem[set_base+way] = 1;
        res.hit = found;
        res.way = way[2:0];
        return res;
    endfunction

    // send one word, waiting out the handshake; valid stays up for a following word
    task automatic send_word(logic cmd, logic [31:0] addr, logic [7:0] wdata);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, wdata, addr, cmd};
        expected_q.push_back(predict_access(cmd, addr, wdata));
        words_sent++;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // random receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        access_result_t got;
        access_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[11:9]};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: hit=%0d data=%h way=%0d",
                             got.hit, got.rdata, got.way);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                words_checked++;
                if (got.hit)
                    hits_seen++;
                if (got !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: exp hit=%0d data=%h way=%0d, got hit=%0d data=%h way=%0d",
                                 words_checked, exp_res.hit, exp_res.rdata, exp_res.way,
                                 got.hit, got.rdata, got.way);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_set_assoc_cache_lru: errors");
            $finish;
        end
    end

    // corner addresses, both commands, fill and eviction of one set
    task automatic test_directed();
        send_word(CMD_READ, 32'h0000_0000, 8'h00);
        send_word(CMD_WRITE, 32'hFFFF_FFFF, 8'hFF);
        send_word(CMD_READ, 32'hFFFF_FFFF, 8'h00);
        send_word(CMD_READ, 32'hFFFF_FFE0, 8'hAA);
        send_word(CMD_WRITE, 32'h0000_001F, 8'h5A);
        send_word(CMD_READ, 32'h0000_001F, 8'hFF);
        // nine tags in set 3 force an eviction of the oldest way
        for (int t = 0; t < 9; t++)
            send_word(t[0] ? CMD_WRITE : CMD_READ, {t[19:0], 7'd3, 5'd7}, t[7:0]);
        send_word(CMD_READ, {20'd1, 7'd3, 5'd7}, 8'h00);
        send_word(CMD_READ, {20'd0, 7'd3, 5'd7}, 8'h00);
        send_word(CMD_READ, {20'd5, 7'd3, 5'd7}, 8'h00);
        drain();
    endtask

    // mostly hits over a few sets with a small tag pool, plus wide noise
    task automatic test_random(int n);
        logic [31:0] addr;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
                addr = {20'(32'hFFFF0 + $urandom_range(11)), 7'($urandom_range(3)),
                        5'($urandom_range(31))};
            else
                addr = $urandom;
            send_word(1'($urandom), addr, 8'($urandom));
        end
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        hits_seen = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            rank_mem[i] = '0;
            tag_mem[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(400);
        send_idle_pct = 53;
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 53;
        test_random(400);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        test_random(430);

        $display("%0d words sent, %0d checked, %0d hits, over directed corners and four",
                 words_sent, words_checked, hits_seen);
        $display("idle/stall phases with set conflicts and evictions");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_set_assoc_cache_lru: clean");
        else
            $display("tb_set_assoc_cache_lru: errors");
        $finish;
    end

endmodule
